// File: rtl/lbc_pkg.sv
// Shared types, constants and helpers for the leg balance controller.
// Used by every module in rtl/; depends on nothing else.

package lbc_pkg;

    // number format
    localparam int FRAC_BITS = 16;
    localparam int GAIN_FRAC = 16;

    // pipeline timing, counted in stages after the input register
    localparam int LAT_WRAP = 5;
    localparam int LAT_PD   = 3;
    localparam int LAT_LQR  = 4;
    localparam int LAT_CORE = LAT_WRAP + LAT_PD;
    localparam int FRC_DLY  = LAT_CORE - LAT_PD;
    localparam int LQR_DLY  = LAT_CORE - LAT_LQR;
    localparam int OUT_STG  = LAT_CORE + 1;

    // rounded widths
    localparam int PD_W  = 36;
    localparam int RND_W = 43;

    // pd gains: kp is a power of two, kd = round(0.8 * 2^16)
    localparam int                 PD_KP_SHIFT = 18;
    localparam logic signed [16:0] PD_KD       = 17'sd52429;

    // angle wrap: pi at FRAC_BITS, modulus 2*pi, bias that keeps the error positive,
    // reciprocal floor(2^34 / modulus)
    localparam int           WRAP_SHIFT    = 34;
    localparam logic [19:0]  WRAP_PI       = 20'd205887;
    localparam logic [18:0]  WRAP_M        = 19'd411774;
    localparam logic [19:0]  WRAP_M_PI     = 20'd617661;
    localparam logic [20:0]  WRAP_2M       = 21'd823548;
    localparam logic [34:0]  WRAP_BIAS     = 35'd4295214594;
    localparam logic [15:0]  WRAP_RECIP    = 16'd41721;

    // lqr gain matrix, Q.16; row 0 wheel torque, row 1 rod torque
    localparam int LQR_ROWS   = 2;
    localparam int LQR_STATES = 6;
    localparam logic signed [24:0] LQR_GAIN [LQR_ROWS][LQR_STATES] = '{
        '{-25'sd5378631, -25'sd758533, -25'sd17701, -25'sd32257, -25'sd8797520,
          -25'sd995092},
        '{ 25'sd4807039,  25'sd618562,  25'sd129263, 25'sd152607, 25'sd9022269,
           25'sd1096555}
    };

    // configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_LEN_L  = 3'd0,
        CFG_REF_LEN_R  = 3'd1,
        CFG_REF_ANG_L  = 3'd2,
        CFG_REF_ANG_R  = 3'd3,
        CFG_JOINT_LIM  = 3'd4,
        CFG_WHEEL_LIM  = 3'd5,
        CFG_TORQUE_SRC = 3'd6
    } t_cfg_idx;

    // rod torque source codes
    localparam logic TSRC_PD  = 1'b0;
    localparam logic TSRC_LQR = 1'b1;

    // reset values
    localparam logic [30:0]        RST_REF_LEN   = 31'd25192;
    localparam logic signed [31:0] RST_REF_ANG_L = -32'sd102944;
    localparam logic signed [31:0] RST_REF_ANG_R = -32'sd91506;
    localparam logic [30:0]        RST_JOINT_LIM = 31'd655360;
    localparam logic [30:0]        RST_WHEEL_LIM = 31'd327680;

    typedef struct packed {
        logic [30:0]        ref_len_l;
        logic [30:0]        ref_len_r;
        logic signed [31:0] ref_ang_l;
        logic signed [31:0] ref_ang_r;
        logic [30:0]        joint_limit;
        logic [30:0]        wheel_limit;
        logic               torque_src;
    } t_cfg;

    typedef struct packed {
        logic               leg_sel;
        logic signed [31:0] length_now;
        logic signed [31:0] length_rate;
        logic signed [31:0] angle_now;
        logic signed [31:0] angle_rate;
        logic signed [31:0] tilt;
        logic signed [31:0] tilt_rate;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] pitch;
        logic signed [31:0] pitch_rate;
    } t_in_req;

    typedef struct packed {
        logic               leg_out;
        logic signed [31:0] rod_force;
        logic signed [31:0] rod_torque;
        logic signed [31:0] wheel_torque;
    } t_out_resp;

    // symmetric saturation; a zero limit gives zero
    function automatic logic signed [31:0] clamp_sym(input logic signed [RND_W-1:0] v,
                                                     input logic [30:0] lim);
        logic signed [RND_W-1:0] hi;
        logic signed [RND_W-1:0] lo;
        logic signed [RND_W-1:0] res;
        hi = $signed({{(RND_W-31){1'b0}}, lim});
        lo = -hi;
        if (v > hi) begin
            res = hi;
        end else if (v < lo) begin
            res = lo;
        end else begin
            res = v;
        end
        return res[31:0];
    endfunction

endpackage

// File: rtl/lbc_cfg.sv
// Configuration register file of the leg balance controller.
// Depends on lbc_pkg for the register map and reset values.

module lbc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lbc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output lbc_pkg::t_cfg                  o_cfg
);
    import lbc_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_len_l   <= RST_REF_LEN;
            r_cfg.ref_len_r   <= RST_REF_LEN;
            r_cfg.ref_ang_l   <= RST_REF_ANG_L;
            r_cfg.ref_ang_r   <= RST_REF_ANG_R;
            r_cfg.joint_limit <= RST_JOINT_LIM;
            r_cfg.wheel_limit <= RST_WHEEL_LIM;
            r_cfg.torque_src  <= TSRC_LQR;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_REF_LEN_L:  r_cfg.ref_len_l   <= i_cfg_wdata[30:0];
                CFG_REF_LEN_R:  r_cfg.ref_len_r   <= i_cfg_wdata[30:0];
                CFG_REF_ANG_L:  r_cfg.ref_ang_l   <= i_cfg_wdata;
                CFG_REF_ANG_R:  r_cfg.ref_ang_r   <= i_cfg_wdata;
                CFG_JOINT_LIM:  r_cfg.joint_limit <= i_cfg_wdata[30:0];
                CFG_WHEEL_LIM:  r_cfg.wheel_limit <= i_cfg_wdata[30:0];
                CFG_TORQUE_SRC: r_cfg.torque_src  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/lbc_pd.sv
// Three-stage PD term: 4.0 * err - 0.8 * rate, rounded from Q.16 gains.
// Depends on lbc_pkg for gains and widths.

module lbc_pd (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [32:0]               i_err,
    input  logic signed [31:0]               i_rate,
    output logic signed [lbc_pkg::PD_W-1:0]  o_value
);
    import lbc_pkg::*;

    logic signed [32:0]     r_err;
    logic signed [48:0]     r_rate_p;
    logic signed [51:0]     r_sum;
    logic signed [51:0]     n_sum;
    logic signed [51:0]     n_rnd;
    logic signed [PD_W-1:0] r_value;

    // kp is a shift, kd a multiplier
    assign n_sum = $signed({r_err[32], r_err, {PD_KP_SHIFT{1'b0}}})
                 - 52'(r_rate_p);
    // round to nearest, ties up
    assign n_rnd = r_sum + $signed(52'(1) <<< (GAIN_FRAC - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_err    <= i_err;
            r_rate_p <= i_rate * PD_KD;
            r_sum    <= n_sum;
            r_value  <= n_rnd[GAIN_FRAC +: PD_W];
        end
    end

    assign o_value = r_value;

endmodule

// File: rtl/lbc_wrap.sv
// Five-stage reduction of the leg angle error into (-pi, pi].
// Modulo by 2*pi through a reciprocal multiply and a final correction; uses lbc_pkg.

module lbc_wrap (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_ref,
    input  logic signed [31:0] i_now,
    output logic signed [19:0] o_err
);
    import lbc_pkg::*;

    logic signed [32:0] n_d;
    logic [34:0]        n_u;
    logic [33:0]        r_u;
    logic [33:0]        r_u2;
    logic [33:0]        r_u3;
    logic [49:0]        r_pq;
    logic [34:0]        r_qm;
    logic [33:0]        n_r0;
    logic [19:0]        r_r0;
    logic signed [20:0] n_wr;
    logic signed [19:0] r_wr;

    // biased error is positive and has the same residue
    assign n_d  = 33'(i_ref) - 33'(i_now);
    assign n_u  = 35'(n_d) + WRAP_BIAS;
    // remainder estimate lies in [0, 2m)
    assign n_r0 = r_u3 - r_qm[33:0];

    // fold the remainder into (-pi, pi]
    always_comb begin
        if (r_r0 > WRAP_M_PI) begin
            n_wr = $signed(21'(r_r0) - WRAP_2M);
        end else if (r_r0 > WRAP_PI) begin
            n_wr = $signed(21'(r_r0) - 21'(WRAP_M));
        end else begin
            n_wr = $signed(21'(r_r0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u  <= n_u[33:0];
            r_pq <= r_u * WRAP_RECIP;
            r_u2 <= r_u;
            r_qm <= r_pq[WRAP_SHIFT +: 16] * WRAP_M;
            r_u3 <= r_u2;
            r_r0 <= n_r0[19:0];
            r_wr <= n_wr[19:0];
        end
    end

    assign o_err = r_wr;

endmodule

// File: rtl/lbc_lqr.sv
// Four-stage 2x6 LQR gain product: multiply, pair sums, row sums, rounding.
// Depends on lbc_pkg for the gain matrix and the request type.

module lbc_lqr (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  lbc_pkg::t_in_req                 i_req,
    output logic signed [lbc_pkg::RND_W-1:0] o_row0,
    output logic signed [lbc_pkg::RND_W-1:0] o_row1
);
    import lbc_pkg::*;

    logic signed [31:0]      w_st   [LQR_STATES];
    logic signed [56:0]      r_prod [LQR_ROWS][LQR_STATES];
    logic signed [57:0]      r_pair [LQR_ROWS][LQR_STATES/2];
    logic signed [58:0]      r_sum  [LQR_ROWS];
    logic signed [58:0]      n_rnd  [LQR_ROWS];
    logic signed [RND_W-1:0] r_row  [LQR_ROWS];

    // state vector in gain column order
    assign w_st[0] = i_req.tilt;
    assign w_st[1] = i_req.tilt_rate;
    assign w_st[2] = i_req.position;
    assign w_st[3] = i_req.velocity;
    assign w_st[4] = i_req.pitch;
    assign w_st[5] = i_req.pitch_rate;

    // round to nearest, ties up
    always_comb begin
        for (int r = 0; r < LQR_ROWS; r++) begin
            n_rnd[r] = r_sum[r] + $signed(59'(1) <<< (GAIN_FRAC - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < LQR_ROWS; r++) begin
                for (int k = 0; k < LQR_STATES; k++) begin
                    r_prod[r][k] <= w_st[k] * LQR_GAIN[r][k];
                end
                for (int j = 0; j < LQR_STATES/2; j++) begin
                    r_pair[r][j] <= 58'(r_prod[r][2*j]) + 58'(r_prod[r][2*j+1]);
                end
                r_sum[r] <= 59'(r_pair[r][0]) + 59'(r_pair[r][1]) + 59'(r_pair[r][2]);
                r_row[r] <= n_rnd[r][GAIN_FRAC +: RND_W];
            end
        end
    end

    assign o_row0 = r_row[0];
    assign o_row1 = r_row[1];

endmodule

// File: rtl/legged_balance_lqr_pd_controller_core.sv
// Leg balance controller: PD leg force, PD or LQR rod torque, LQR wheel torque.
// Path: input register, PD, wrap and LQR stages, delay lines, output register.
// Throughput: one request per cycle; an output stall freezes the whole pipeline,
// so the input stalls only while a finished result waits.
// Reset clears the pipeline valid flags and restores the configuration defaults.
// Depends on lbc_pkg, lbc_cfg, lbc_pd, lbc_wrap and lbc_lqr.

module legged_balance_lqr_pd_controller_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  lbc_pkg::t_in_req               i_in_req,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output lbc_pkg::t_out_resp             o_out_resp,
    input  logic                           i_cfg_we,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lbc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import lbc_pkg::*;

    t_cfg                    w_cfg;
    logic                    w_en;
    logic [OUT_STG:0]        r_vld;
    t_in_req                 r_req;
    logic [30:0]             w_ref_len;
    logic signed [31:0]      w_ref_ang;
    logic signed [32:0]      w_len_err;
    logic signed [PD_W-1:0]  w_frc;
    logic signed [19:0]      w_wrap_err;
    logic signed [PD_W-1:0]  w_ang_pd;
    logic signed [RND_W-1:0] w_row0;
    logic signed [RND_W-1:0] w_row1;
    logic                    r_leg_dly  [LAT_CORE];
    logic signed [31:0]      r_rate_dly [LAT_WRAP];
    logic signed [PD_W-1:0]  r_frc_dly  [FRC_DLY];
    logic signed [RND_W-1:0] r_row0_dly [LQR_DLY];
    logic signed [RND_W-1:0] r_row1_dly [LQR_DLY];
    t_out_resp               n_resp;
    t_out_resp               r_resp;

    lbc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // pipeline advances unless a finished result is held
    assign w_en        = !(r_vld[OUT_STG] && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_out_valid = r_vld[OUT_STG];
    assign o_out_resp  = r_resp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[OUT_STG-1:0], i_in_valid};
        end
    end

    // per-leg targets
    assign w_ref_len = r_req.leg_sel ? w_cfg.ref_len_r : w_cfg.ref_len_l;
    assign w_ref_ang = r_req.leg_sel ? w_cfg.ref_ang_r : w_cfg.ref_ang_l;
    assign w_len_err = $signed({2'b00, w_ref_len}) - 33'($signed(r_req.length_now));

    // leg length pd
    lbc_pd u_len_pd (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_err   (w_len_err),
        .i_rate  (r_req.length_rate),
        .o_value (w_frc)
    );

    // wrapped leg angle pd
    lbc_wrap u_wrap (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ref (w_ref_ang),
        .i_now (r_req.angle_now),
        .o_err (w_wrap_err)
    );

    lbc_pd u_ang_pd (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_err   (33'(w_wrap_err)),
        .i_rate  (r_rate_dly[LAT_WRAP-1]),
        .o_value (w_ang_pd)
    );

    // lqr rows
    lbc_lqr u_lqr (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_req  (r_req),
        .o_row0 (w_row0),
        .o_row1 (w_row1)
    );

    // input register and alignment delay lines
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_req         <= i_in_req;
            r_leg_dly[0]  <= r_req.leg_sel;
            r_rate_dly[0] <= r_req.angle_rate;
            r_frc_dly[0]  <= w_frc;
            r_row0_dly[0] <= w_row0;
            r_row1_dly[0] <= w_row1;
            for (int k = 1; k < LAT_CORE; k++) begin
                r_leg_dly[k] <= r_leg_dly[k-1];
            end
            for (int k = 1; k < LAT_WRAP; k++) begin
                r_rate_dly[k] <= r_rate_dly[k-1];
            end
            for (int k = 1; k < FRC_DLY; k++) begin
                r_frc_dly[k] <= r_frc_dly[k-1];
            end
            for (int k = 1; k < LQR_DLY; k++) begin
                r_row0_dly[k] <= r_row0_dly[k-1];
                r_row1_dly[k] <= r_row1_dly[k-1];
            end
        end
    end

    // torque source select and saturation
    always_comb begin
        n_resp.leg_out   = r_leg_dly[LAT_CORE-1];
        n_resp.rod_force = clamp_sym(RND_W'(r_frc_dly[FRC_DLY-1]), w_cfg.joint_limit);
        if (w_cfg.torque_src == TSRC_PD) begin
            n_resp.rod_torque = clamp_sym(RND_W'(w_ang_pd), w_cfg.joint_limit);
        end else begin
            n_resp.rod_torque = clamp_sym(r_row1_dly[LQR_DLY-1], w_cfg.joint_limit);
        end
        n_resp.wheel_torque = clamp_sym(r_row0_dly[LQR_DLY-1], w_cfg.wheel_limit);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_resp <= n_resp;
        end
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for legged_balance_lqr_pd_controller_core: directed and random control
// ticks, each checked against a fixed-point controller predictor kept in the bench.
// Depends on lbc_pkg and the controller RTL.

module testbench;
    import lbc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
    localparam int     SETTLE_CYCLES = 12;
    localparam longint KP_Q16        = 262144;
    localparam longint KD_Q16        = 52429;
    localparam longint PI_FIX        = 205887;
    localparam longint TWO_PI_FIX    = 411774;
    localparam logic [31:0] W_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN    = 32'h8000_0000;
    localparam logic [31:0] W_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] W_HALF   = 32'h0000_8000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_req               in_req    = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_resp             out_resp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  hold_on   = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned err_cnt       = 0;

    // register copies used by the predictor
    longint ref_len_s [2];
    longint ref_ang_s [2];
    longint joint_lim_s;
    longint wheel_lim_s;
    logic   tsrc_s;

    t_out_resp expected_resp [$];

    legged_balance_lqr_pd_controller_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_resp  (out_resp),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // round to nearest, ties up, from 16 fraction bits of gain
    function automatic longint round_q16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint sat_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // reduce an angle error into (-pi, pi]
    function automatic longint wrap_pi(input longint d);
        longint r;
        r = d % TWO_PI_FIX;
        if (r < 0) r += TWO_PI_FIX;
        if (r > PI_FIX) r -= TWO_PI_FIX;
        return r;
    endfunction

    // one row of the lqr gain matrix times the six state values
    function automatic longint lqr_torque(input bit row, input t_in_req r);
        longint th, thd, x, xd, ph, phd, acc;
        th  = longint'($signed(r.tilt));
        thd = longint'($signed(r.tilt_rate));
        x   = longint'($signed(r.position));
        xd  = longint'($signed(r.velocity));
        ph  = longint'($signed(r.pitch));
        phd = longint'($signed(r.pitch_rate));
        if (row)
            acc = 64'sd4807039 * th + 64'sd618562 * thd + 64'sd129263 * x
                + 64'sd152607 * xd + 64'sd9022269 * ph + 64'sd1096555 * phd;
        else
            acc = -64'sd5378631 * th - 64'sd758533 * thd - 64'sd17701 * x
                - 64'sd32257 * xd - 64'sd8797520 * ph - 64'sd995092 * phd;
        return round_q16(acc);
    endfunction

    // expected commands for one control tick
    function automatic t_out_resp predict_control(input t_in_req r);
        t_out_resp p;
        longint    force_v, torque_v, wheel_v, ang_err;
        force_v = round_q16(KP_Q16 * (ref_len_s[r.leg_sel] - longint'($signed(r.length_now)))
                            - KD_Q16 * longint'($signed(r.length_rate)));
        if (tsrc_s == TSRC_PD) begin
            ang_err  = wrap_pi(ref_ang_s[r.leg_sel] - longint'($signed(r.angle_now)));
            torque_v = round_q16(KP_Q16 * ang_err - KD_Q16 * longint'($signed(r.angle_rate)));
        end else begin
            torque_v = lqr_torque(1'b1, r);
        end
        wheel_v        = lqr_torque(1'b0, r);
        p.leg_out      = r.leg_sel;
        p.rod_force    = 32'(sat_sym(force_v, joint_lim_s));
        p.rod_torque   = 32'(sat_sym(torque_v, joint_lim_s));
        p.wheel_torque = 32'(sat_sym(wheel_v, wheel_lim_s));
        return p;
    endfunction

    // mostly small physical values, some full range, some extremes
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(7))
            0, 1, 2, 3: w = 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
            4, 5:       w = $urandom;
            6: begin
                case ($urandom_range(4))
                    0:       w = W_MIN;
                    1:       w = W_MAX;
                    2:       w = '0;
                    3:       w = W_ONES;
                    default: w = W_HALF;
                endcase
            end
            default:    w = 32'($urandom_range(0, 32'h3FFFFFF)) - 32'h2000000;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] pick_limit();
        logic [31:0] w;
        case ($urandom_range(5))
            0:       w = '0;
            1:       w = W_ONES;
            2:       w = $urandom;
            default: w = 32'($urandom_range(1, 32'h7FFFFF));
        endcase
        return w;
    endfunction

    function automatic t_in_req uniform_tick(input logic leg, input logic [31:0] w);
        t_in_req r;
        r.leg_sel     = leg;
        r.length_now  = w;
        r.length_rate = w;
        r.angle_now   = w;
        r.angle_rate  = w;
        r.tilt        = w;
        r.tilt_rate   = w;
        r.position    = w;
        r.velocity    = w;
        r.pitch       = w;
        r.pitch_rate  = w;
        return r;
    endfunction

    function automatic t_in_req random_tick();
        t_in_req r;
        r.leg_sel     = 1'($urandom_range(1));
        r.length_now  = pick_word();
        r.length_rate = pick_word();
        r.angle_now   = pick_word();
        r.angle_rate  = pick_word();
        r.tilt        = pick_word();
        r.tilt_rate   = pick_word();
        r.position    = pick_word();
        r.velocity    = pick_word();
        r.pitch       = pick_word();
        r.pitch_rate  = pick_word();
        return r;
    endfunction

    // offer one request, with random gaps, until the block takes it
    task automatic send_tick(input t_in_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_resp.push_back(predict_control(req));
    endtask

    // stop offering and let the pipeline empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_resp.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write, block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_REF_LEN_L:  ref_len_s[0] = longint'(data[30:0]);
            CFG_REF_LEN_R:  ref_len_s[1] = longint'(data[30:0]);
            CFG_REF_ANG_L:  ref_ang_s[0] = longint'($signed(data));
            CFG_REF_ANG_R:  ref_ang_s[1] = longint'($signed(data));
            CFG_JOINT_LIM:  joint_lim_s  = longint'(data[30:0]);
            CFG_WHEEL_LIM:  wheel_lim_s  = longint'(data[30:0]);
            CFG_TORQUE_SRC: tsrc_s       = data[0];
            default: ;
        endcase
    endtask

    // result checker and receiver stall
    always @(posedge clk) begin : result_check
        t_out_resp e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_resp.size() == 0) begin
                $display("%0t: unexpected result: leg=%0d force=%0d torque=%0d wheel=%0d",
                         $time, out_resp.leg_out, out_resp.rod_force, out_resp.rod_torque,
                         out_resp.wheel_torque);
                err_cnt++;
            end else begin
                e = expected_resp.pop_front();
                if (out_resp.leg_out !== e.leg_out || out_resp.rod_force !== e.rod_force ||
                    out_resp.rod_torque !== e.rod_torque ||
                    out_resp.wheel_torque !== e.wheel_torque) begin
                    $display("%0t: mismatch: expected leg=%0d force=%0d torque=%0d wheel=%0d",
                             $time, e.leg_out, e.rod_force, e.rod_torque, e.wheel_torque);
                    $display("%0t:           actual   leg=%0d force=%0d torque=%0d wheel=%0d",
                             $time, out_resp.leg_out, out_resp.rod_force,
                             out_resp.rod_torque, out_resp.wheel_torque);
                    err_cnt++;
                end
            end
        end
        out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
    end

    // default registers, lqr rod torque, field extremes and rounding ties
    task automatic test_reset_defaults();
        send_tick(uniform_tick(1'b0, '0));
        send_tick(uniform_tick(1'b1, '0));
        send_tick(uniform_tick(1'b1, W_MAX));
        send_tick(uniform_tick(1'b0, W_MIN));
        send_tick(uniform_tick(1'b0, W_ONES));
        send_tick(uniform_tick(1'b1, W_HALF));
    endtask

    // leg-angle pd with wrap at +pi, -pi and just past, plus rounding ties
    task automatic test_angle_wrap();
        t_in_req r;
        wait_idle();
        write_reg(CFG_TORQUE_SRC, 32'(TSRC_PD));
        r = uniform_tick(1'b0, '0);
        r.angle_now = 32'(-102944 - 205887);
        send_tick(r);
        r.angle_now = 32'(-102944 + 205887);
        send_tick(r);
        r.angle_now  = W_MIN;
        r.angle_rate = W_MAX;
        send_tick(r);
        r.angle_now  = 32'(-102944);
        r.angle_rate = W_HALF;
        send_tick(r);
        r = uniform_tick(1'b1, '0);
        r.angle_now = 32'(-91506 - 205888);
        send_tick(r);
        r.angle_now  = W_MAX;
        r.angle_rate = W_MIN;
        send_tick(r);
        r.angle_now  = 32'(-91506);
        r.angle_rate = 32'(-32768);
        send_tick(r);
    endtask

    // zero and full limits, extreme targets, ignored register index
    task automatic test_limit_edges();
        wait_idle();
        write_reg(CFG_JOINT_LIM, '0);
        write_reg(CFG_WHEEL_LIM, '0);
        write_reg(CFG_IDX_UNUSED, W_ONES);
        send_tick(uniform_tick(1'b0, W_MAX));
        send_tick(uniform_tick(1'b1, 32'h0000_1000));
        wait_idle();
        write_reg(CFG_JOINT_LIM, W_ONES);
        write_reg(CFG_WHEEL_LIM, W_ONES);
        write_reg(CFG_REF_LEN_L, '0);
        write_reg(CFG_REF_LEN_R, W_ONES);
        write_reg(CFG_REF_ANG_L, W_MIN);
        write_reg(CFG_REF_ANG_R, W_MAX);
        send_tick(uniform_tick(1'b0, W_MIN));
        send_tick(uniform_tick(1'b1, W_MIN));
        send_tick(uniform_tick(1'b1, W_MAX));
        send_tick(uniform_tick(1'b0, W_MAX));
        wait_idle();
        write_reg(CFG_TORQUE_SRC, 32'(TSRC_LQR));
        send_tick(uniform_tick(1'b0, 32'h0001_0000));
        send_tick(uniform_tick(1'b1, W_MIN));
    endtask

    // random ticks under several register sets and idle patterns
    task automatic test_random_traffic();
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0:       begin send_idle_pct = 9;  recv_idle_pct = 51; end
                1:       begin send_idle_pct = 51; recv_idle_pct = 9;  end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (int set = 0; set < 3; set++) begin
                wait_idle();
                write_reg(CFG_REF_LEN_L, pick_word());
                write_reg(CFG_REF_LEN_R, pick_word());
                write_reg(CFG_REF_ANG_L, pick_word());
                write_reg(CFG_REF_ANG_R, pick_word());
                write_reg(CFG_JOINT_LIM, pick_limit());
                write_reg(CFG_WHEEL_LIM, pick_limit());
                write_reg(CFG_TORQUE_SRC, $urandom);
                repeat (150) send_tick(random_tick());
            end
        end
    endtask

    // long output hold while requests keep coming, so the input stalls
    task automatic test_output_hold();
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                hold_on <= 1'b1;
                repeat (300) @(posedge clk);
                hold_on <= 1'b0;
            end
        join_none
        repeat (64) send_tick(random_tick());
    endtask

    initial begin
        ref_len_s[0] = 25192;
        ref_len_s[1] = 25192;
        ref_ang_s[0] = -102944;
        ref_ang_s[1] = -91506;
        joint_lim_s  = 655360;
        wheel_lim_s  = 327680;
        tsrc_s       = TSRC_LQR;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_angle_wrap();
        test_limit_edges();
        test_random_traffic();
        test_output_hold();
        wait_idle();

        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
